// ===== rtl/core/sgi_pkg.sv =====
// Shared constants for the segment intersection pipeline.
package sgi_pkg;

  // Default coordinate width (signed fixed point, Q8.8 by default).
  localparam int unsigned COORD_BITS_DEF = 16;
  // Pipeline stages beyond the one-bit-per-stage quotient steps.
  localparam int unsigned PIPE_EXTRA     = 9;

endpackage

// ===== rtl/core/sgi_req_if.sv =====
// Request channel: two segments, four endpoints.
interface sgi_req_if
  import sgi_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_start_x;
  logic signed [COORD_BITS-1:0] first_start_y;
  logic signed [COORD_BITS-1:0] first_end_x;
  logic signed [COORD_BITS-1:0] first_end_y;
  logic signed [COORD_BITS-1:0] second_start_x;
  logic signed [COORD_BITS-1:0] second_start_y;
  logic signed [COORD_BITS-1:0] second_end_x;
  logic signed [COORD_BITS-1:0] second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface

// ===== rtl/core/sgi_rsp_if.sv =====
// Response channel: crossing point and flags.
interface sgi_rsp_if
  import sgi_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         is_parallel;
  logic                         is_hit;
  logic signed [COORD_BITS-1:0] cross_x;
  logic signed [COORD_BITS-1:0] cross_y;

  modport source (
    output valid, is_parallel, is_hit, cross_x, cross_y,
    input  ready
  );
  modport sink (
    input  valid, is_parallel, is_hit, cross_x, cross_y,
    output ready
  );
endinterface

// ===== rtl/core/segment_intersection_top.sv =====
// Segment pair intersection: deep pipeline with a bit-per-stage divider.
//
//  channel | dir | carries
//  --------+-----+-------------------------------------------------
//  req_i   | in  | first/second segment start and end points
//  rsp_o   | out | is_parallel, is_hit, cross_x, cross_y
//
// One request enters every cycle unless a stalled response has backed up
// to the first stage. The depth is set by the quotient, which resolves one
// bit per stage. Every stage holds a valid bit and advances when it is empty
// or the stage after it advances, so a stalled response backs up only as far
// as needed and bubbles are squeezed out. Reset clears the valid bits only.
module segment_intersection_top
  import sgi_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sgi_req_if.sink    req_i,
  sgi_rsp_if.source  rsp_o
);

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;          // coordinate difference
  localparam int PW = 2 * C;          // coordinate product
  localparam int QW = 2 * C + 2;      // difference product
  localparam int EW = 2 * C + 3;      // denominator
  localparam int KW = 2 * C + 1;      // line constant
  localparam int MW = 3 * C + 2;      // numerator product
  localparam int NW = 3 * C + 3;      // numerator
  localparam int DM = 2 * C + 2;      // denominator magnitude
  localparam int NS = C + PIPE_EXTRA; // total stages
  localparam int SD = 6;              // overflow check stage
  localparam int SS = C + 7;          // saturation stage
  localparam int SO = C + 8;          // output stage

  localparam logic [C-1:0] BND_POS = {1'b0, {(C-1){1'b1}}};
  localparam logic [C-1:0] BND_NEG = {1'b1, {(C-1){1'b0}}};

  typedef logic [7:0][C-1:0] crd_t;
  typedef struct packed {
    logic [NW-1:0] rx;
    logic [NW-1:0] ry;
    logic [C-1:0]  qx;
    logic [C-1:0]  qy;
    logic [DM-1:0] dm;
    logic          ox;
    logic          oy;
    logic          ngx;
    logic          ngy;
    logic          par;
  } div_t;

  // Stall control: a stage takes new data when empty or draining.
  logic [NS-1:0] v_q, en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || rsp_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign req_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= req_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Endpoints travel up to the saturation stage for the final range test.
  crd_t crd_q [SO];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      crd_q[0] <= {req_i.second_end_y, req_i.second_end_x,
                   req_i.second_start_y, req_i.second_start_x,
                   req_i.first_end_y, req_i.first_end_x,
                   req_i.first_start_y, req_i.first_start_x};
    end
    for (int k = 1; k < SO; k++) begin
      if (en[k]) begin
        crd_q[k] <= crd_q[k-1];
      end
    end
  end

  // Stage 0: coordinate differences.
  logic signed [DW-1:0] dx12_q, dy12_q, dx34_q, dy34_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dx12_q <= DW'(req_i.first_start_x) - DW'(req_i.first_end_x);
      dy12_q <= DW'(req_i.first_start_y) - DW'(req_i.first_end_y);
      dx34_q <= DW'(req_i.second_start_x) - DW'(req_i.second_end_x);
      dy34_q <= DW'(req_i.second_start_y) - DW'(req_i.second_end_y);
    end
  end

  // Stage 1: six products.
  logic signed [QW-1:0] pa_q, pb_q;
  logic signed [PW-1:0] ca_q, cb_q, cc_q, cd_q;
  logic signed [DW-1:0] dx12_1q, dy12_1q, dx34_1q, dy34_1q;
  logic signed [C-1:0]  x1, y1, x2, y2, x3, y3, x4, y4;

  always_comb begin
    x1 = $signed(crd_q[0][0]);
    y1 = $signed(crd_q[0][1]);
    x2 = $signed(crd_q[0][2]);
    y2 = $signed(crd_q[0][3]);
    x3 = $signed(crd_q[0][4]);
    y3 = $signed(crd_q[0][5]);
    x4 = $signed(crd_q[0][6]);
    y4 = $signed(crd_q[0][7]);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pa_q    <= dx12_q * dy34_q;
      pb_q    <= dy12_q * dx34_q;
      ca_q    <= x1 * y2;
      cb_q    <= y1 * x2;
      cc_q    <= x3 * y4;
      cd_q    <= y3 * x4;
      dx12_1q <= dx12_q;
      dy12_1q <= dy12_q;
      dx34_1q <= dx34_q;
      dy34_1q <= dy34_q;
    end
  end

  // Stage 2: denominator and line constants.
  logic signed [EW-1:0] den2_q;
  logic signed [KW-1:0] c12_q, c34_q;
  logic signed [DW-1:0] dx12_2q, dy12_2q, dx34_2q, dy34_2q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      den2_q  <= EW'(pa_q) - EW'(pb_q);
      c12_q   <= KW'(ca_q) - KW'(cb_q);
      c34_q   <= KW'(cc_q) - KW'(cd_q);
      dx12_2q <= dx12_1q;
      dy12_2q <= dy12_1q;
      dx34_2q <= dx34_1q;
      dy34_2q <= dy34_1q;
    end
  end

  // Stage 3: numerator products.
  logic signed [MW-1:0] m1_q, m2_q, m3_q, m4_q;
  logic signed [EW-1:0] den3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      m1_q   <= c12_q * dx34_2q;
      m2_q   <= dx12_2q * c34_q;
      m3_q   <= c12_q * dy34_2q;
      m4_q   <= dy12_2q * c34_q;
      den3_q <= den2_q;
    end
  end

  // Stage 4: numerators, exact zero test on the denominator.
  logic signed [NW-1:0] nx_q, ny_q;
  logic signed [EW-1:0] den4_q;
  logic                 par4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      nx_q   <= NW'(m1_q) - NW'(m2_q);
      ny_q   <= NW'(m3_q) - NW'(m4_q);
      den4_q <= den3_q;
      par4_q <= (den3_q == '0);
    end
  end

  // Stage 5: magnitudes and quotient signs.
  logic [NW-1:0] nmx_q, nmy_q;
  logic [DM-1:0] dm5_q;
  logic          ngx5_q, ngy5_q, par5_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      nmx_q  <= nx_q[NW-1] ? NW'(-nx_q) : NW'(nx_q);
      nmy_q  <= ny_q[NW-1] ? NW'(-ny_q) : NW'(ny_q);
      dm5_q  <= den4_q[EW-1] ? DM'(-den4_q) : DM'(den4_q);
      ngx5_q <= nx_q[NW-1] ^ den4_q[EW-1];
      ngy5_q <= ny_q[NW-1] ^ den4_q[EW-1];
      par5_q <= par4_q;
    end
  end

  // Stage 6: flag quotients of more than COORD_BITS magnitude bits.
  div_t div_q [C+1];

  always_ff @(posedge clk_i) begin
    if (en[SD]) begin
      div_q[0].rx  <= nmx_q;
      div_q[0].ry  <= nmy_q;
      div_q[0].qx  <= '0;
      div_q[0].qy  <= '0;
      div_q[0].dm  <= dm5_q;
      div_q[0].ox  <= {1'b0, nmx_q} >= ((NW+1)'(dm5_q) << C);
      div_q[0].oy  <= {1'b0, nmy_q} >= ((NW+1)'(dm5_q) << C);
      div_q[0].ngx <= ngx5_q;
      div_q[0].ngy <= ngy5_q;
      div_q[0].par <= par5_q;
    end
  end

  // Restoring division, one quotient bit per stage, MSB first.
  for (genvar j = 1; j <= C; j++) begin : g_div
    localparam int B = C - j;
    logic [NW:0] sh, tx, ty;
    div_t        nxt;

    always_comb begin
      nxt = div_q[j-1];
      sh  = (NW+1)'(div_q[j-1].dm) << B;
      tx  = {1'b0, div_q[j-1].rx} - sh;
      ty  = {1'b0, div_q[j-1].ry} - sh;
      if (!tx[NW]) begin
        nxt.rx    = tx[NW-1:0];
        nxt.qx[B] = 1'b1;
      end
      if (!ty[NW]) begin
        nxt.ry    = ty[NW-1:0];
        nxt.qy[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[SD+j]) begin
        div_q[j] <= nxt;
      end
    end
  end

  // Saturation stage: clamp magnitude, apply sign, zero on parallel.
  logic [C-1:0] bx, by, mx, my;
  logic [C-1:0] qx_q, qy_q;
  logic         par_s_q;

  always_comb begin
    bx = div_q[C].ngx ? BND_NEG : BND_POS;
    by = div_q[C].ngy ? BND_NEG : BND_POS;
    mx = (div_q[C].ox || (div_q[C].qx > bx)) ? bx : div_q[C].qx;
    my = (div_q[C].oy || (div_q[C].qy > by)) ? by : div_q[C].qy;
  end

  always_ff @(posedge clk_i) begin
    if (en[SS]) begin
      qx_q    <= div_q[C].par ? '0 : (div_q[C].ngx ? C'(-mx) : mx);
      qy_q    <= div_q[C].par ? '0 : (div_q[C].ngy ? C'(-my) : my);
      par_s_q <= div_q[C].par;
    end
  end

  // Output stage: closed range test against both segments.
  function automatic logic in_span(input logic signed [C-1:0] v,
                                   input logic signed [C-1:0] a,
                                   input logic signed [C-1:0] b);
    return ((a <= v) && (v <= b)) || ((b <= v) && (v <= a));
  endfunction

  logic signed [C-1:0] sx, sy;
  crd_t                cs;
  logic                hit;
  logic                par_o_q, hit_o_q;
  logic [C-1:0]        cx_o_q, cy_o_q;

  always_comb begin
    cs  = crd_q[SS];
    sx  = $signed(qx_q);
    sy  = $signed(qy_q);
    hit = !par_s_q &&
          in_span(sx, $signed(cs[0]), $signed(cs[2])) &&
          in_span(sx, $signed(cs[4]), $signed(cs[6])) &&
          in_span(sy, $signed(cs[1]), $signed(cs[3])) &&
          in_span(sy, $signed(cs[5]), $signed(cs[7]));
  end

  always_ff @(posedge clk_i) begin
    if (en[SO]) begin
      par_o_q <= par_s_q;
      hit_o_q <= hit;
      cx_o_q  <= qx_q;
      cy_o_q  <= qy_q;
    end
  end

  assign rsp_o.valid       = v_q[NS-1];
  assign rsp_o.is_parallel = par_o_q;
  assign rsp_o.is_hit      = hit_o_q;
  assign rsp_o.cross_x     = $signed(cx_o_q);
  assign rsp_o.cross_y     = $signed(cy_o_q);

endmodule

// ===== rtl/core/sgi_checker.sv =====
// Port-level checks for the segment intersection pipeline, bound to the top.
module sgi_checker
  import sgi_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned DEPTH      = COORD_BITS_DEF + PIPE_EXTRA
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic                  out_par_i,
  input logic                  out_hit_i,
  input logic [COORD_BITS-1:0] out_x_i,
  input logic [COORD_BITS-1:0] out_y_i
);

  localparam int CW = $clog2(DEPTH + 1) + 1;

  logic          in_acc, out_acc;
  logic [CW-1:0] cnt_q, cnt_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_par_i) &&
    $stable(out_hit_i) && $stable(out_x_i) && $stable(out_y_i))
    else $error("response changed while stalled");

  a_par_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_par_i |-> !out_hit_i && out_x_i == '0 && out_y_i == '0)
    else $error("parallel response carries a point or hit");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("response without an outstanding request");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("more requests in flight than pipeline stages");

endmodule

bind segment_intersection_top sgi_checker #(
  .COORD_BITS (COORD_BITS),
  .DEPTH      (COORD_BITS + sgi_pkg::PIPE_EXTRA)
) u_sgi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_par_i   (rsp_o.is_parallel),
  .out_hit_i   (rsp_o.is_hit),
  .out_x_i     (rsp_o.cross_x),
  .out_y_i     (rsp_o.cross_y)
);
